// ===== hw/rtl/magma_pkg.sv =====
// Magma cipher shared definitions: round count, S-box table, key ordering.
// Stage record type used between the top level and the round stages.
// No dependencies.
package magma_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int FWD_ENC    = 24;   // encrypt: forward key order for the first 24 rounds
    localparam int FWD_DEC    = 8;    // decrypt: forward key order for the first 8 rounds
    localparam int ROT        = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int KEY_W      = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_D = 3'd3;

    localparam logic CMD_DECRYPT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        cmd;
        logic [31:0] hi;
        logic [31:0] lo;
    } stage_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] hi;
        logic [31:0] lo;
    } payload_t;

    typedef logic [3:0] sbox_row_t [16];

    localparam sbox_row_t SBOX [8] = '{
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
    };

    // Eight parallel 4-bit substitutions, box 0 on the lowest nibble
    function automatic logic [31:0] subst(input logic [31:0] x);
        logic [31:0] r;
        r = '0;
        for (int n = 0; n < 8; n++) begin
            r[4*n +: 4] = SBOX[n][x[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [31:0] gfun(input logic [31:0] x, input logic [31:0] k);
        logic [31:0] s;
        s = subst(x + k);
        return {s[31-ROT:0], s[31:32-ROT]};
    endfunction

    // Round key slot: forward order K1..K8 or reverse K8..K1
    function automatic logic [2:0] key_index(input logic [4:0] rnd, input logic dec);
        logic fwd;
        fwd = (dec == CMD_DECRYPT) ? (rnd < 5'(FWD_DEC)) : (rnd < 5'(FWD_ENC));
        return fwd ? rnd[2:0] : ~rnd[2:0];
    endfunction

endpackage

// ===== hw/rtl/magma_round.sv =====
// One Feistel round of the Magma cipher with its pipeline register.
// Depends on magma_pkg (stage_t, payload_t, gfun).
module magma_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  magma_pkg::stage_t up,
    input  logic [31:0]       rkey,
    output magma_pkg::stage_t dn
);
    import magma_pkg::*;

    logic     valid_reg;
    payload_t data_reg;
    payload_t data_next;

    // Swap halves: new high is old low, new low is the round output
    always_comb
    begin
        data_next.cmd = up.cmd;
        data_next.hi  = up.lo;
        data_next.lo  = gfun(up.lo, rkey) ^ up.hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && up.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn.valid = valid_reg;
    assign dn.cmd   = data_reg.cmd;
    assign dn.hi    = data_reg.hi;
    assign dn.lo    = data_reg.lo;

endmodule

// ===== hw/rtl/magma_block_cipher.sv =====
// Magma 64-bit block cipher, fully unrolled 32-stage round pipeline.
// Depends on magma_pkg and magma_round.
//
//   channel   direction  handshake               payload
//   blk       in         blk_valid / blk_stall   cmd, block_in
//   res       out        res_valid / res_stall   block_out
//   cfg       in         cfg_we                  cfg_idx, cfg_data
//
// One register stage per round; one block enters every cycle while blk_stall is low.
// Each stage holds one round (key add, S-boxes, rotate, XOR) of one block.
// Reset clears the stage valid bits and the four key registers.
// A stall on res holds only the filled stages ahead of the first empty one:
// blk_stall stays low while any stage is empty, so bubbles are squeezed out.
module magma_block_cipher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // block input transfer
    input  logic                                 blk_valid,
    output logic                                 blk_stall,
    input  logic                                 cmd,
    input  logic [63:0]                          block_in,
    // result transfer
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [63:0]                          block_out,
    // key register writes
    input  logic                                 cfg_we,
    input  logic [magma_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [magma_pkg::KEY_W-1:0]          cfg_data
);
    import magma_pkg::*;

    logic [KEY_W-1:0] key_a_reg;
    logic [KEY_W-1:0] key_b_reg;
    logic [KEY_W-1:0] key_c_reg;
    logic [KEY_W-1:0] key_d_reg;
    logic [31:0]      kw [8];

    stage_t                st  [NUM_ROUNDS+1];
    logic [NUM_ROUNDS:0]   adv;

    // Key registers; the user must write them only while the pipeline is drained; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg <= '0;
            key_b_reg <= '0;
            key_c_reg <= '0;
            key_d_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_KEY_A: key_a_reg <= cfg_data;
                REG_KEY_B: key_b_reg <= cfg_data;
                REG_KEY_C: key_c_reg <= cfg_data;
                REG_KEY_D: key_d_reg <= cfg_data;
                default:   ; // drop writes beyond the key words
            endcase
        end
    end

    // K1..K8: upper half of each key word first
    assign kw[0] = key_a_reg[63:32];
    assign kw[1] = key_a_reg[31:0];
    assign kw[2] = key_b_reg[63:32];
    assign kw[3] = key_b_reg[31:0];
    assign kw[4] = key_c_reg[63:32];
    assign kw[5] = key_c_reg[31:0];
    assign kw[6] = key_d_reg[63:32];
    assign kw[7] = key_d_reg[31:0];

    // Stage 0 is the incoming transfer itself
    assign st[0].valid = blk_valid;
    assign st[0].cmd   = cmd;
    assign st[0].hi    = block_in[63:32];
    assign st[0].lo    = block_in[31:0];

    // A stage advances when its register is empty or its contents move on
    assign adv[NUM_ROUNDS] = !res_stall;

    genvar r;
    generate
        for (r = 0; r < NUM_ROUNDS; r++)
        begin : g_round
            assign adv[r] = !st[r+1].valid || adv[r+1];

            magma_round u_round (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (adv[r]),
                .up    (st[r]),
                .rkey  (kw[key_index(5'(r), st[r].cmd)]),
                .dn    (st[r+1])
            );
        end
    endgenerate

    assign blk_stall = !adv[0];
    assign res_valid = st[NUM_ROUNDS].valid;
    // The last round has no swap: undo the swap done in the final stage
    assign block_out = {st[NUM_ROUNDS].lo, st[NUM_ROUNDS].hi};

`ifndef NO_ASSERTIONS
    logic                  blk_xfer;
    logic                  res_xfer;
    logic [NUM_ROUNDS-1:0] occ;
    assign blk_xfer = blk_valid && !blk_stall;
    assign res_xfer = res_valid && !res_stall;

    always_comb
    begin
        for (int i = 0; i < NUM_ROUNDS; i++)
        begin
            occ[i] = st[i+1].valid;
        end
    end

    // Any empty stage must let a new block in
    a_no_stall_with_hole: assert property (@(posedge clk) disable iff (!rst_n)
        (occ != '1) |-> !blk_stall)
        else $error("input stalled while a pipeline stage is empty");

    a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_xfer && !res_xfer) |=> ($countones(occ) == $past($countones(occ)) + 1))
        else $error("occupancy did not grow on input-only transfer");

    a_occ_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (!blk_xfer && res_xfer) |=> ($countones(occ) + 1 == $past($countones(occ))))
        else $error("occupancy did not shrink on output-only transfer");

    a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (blk_xfer == res_xfer) |=> ($countones(occ) == $past($countones(occ))))
        else $error("occupancy changed without a net transfer");
`endif

endmodule
